// File: hdl/bpec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpec_pkg
// Shared constants for the button press event classifier: register map, register
// widths and reset values, counter and stream widths, result bit layout, pin levels.
// ----------------------------------------------------------------------------
package bpec_pkg;

  // Counter widths (defaults for the top-level parameters)
  localparam int HOLD_COUNT_BITS_DEF = 16;
  localparam int IDLE_COUNT_BITS_DEF = 32;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS_TICKS = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INACTIVE_ENABLE  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INACTIVE_TICKS   = 3'd3;

  // Register widths
  localparam int LONG_TICKS_BITS     = 16;
  localparam int DEBOUNCE_TICKS_BITS = 16;
  localparam int INACTIVE_TICKS_BITS = 32;

  // Register reset values
  localparam logic [LONG_TICKS_BITS-1:0]     LONG_TICKS_RST     = 16'd500;
  localparam logic [DEBOUNCE_TICKS_BITS-1:0] DEBOUNCE_TICKS_RST = 16'd50;
  localparam logic [INACTIVE_TICKS_BITS-1:0] INACTIVE_TICKS_RST = 32'd0;

  // Stream widths
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 8;
  localparam int NUM_EVENTS     = 6;

  // Result bit positions in out_tdata
  localparam int EV_PRESS     = 0;
  localparam int EV_RELEASE   = 1;
  localparam int EV_SHORT     = 2;
  localparam int EV_LONG      = 3;
  localparam int EV_LONG_REL  = 4;
  localparam int EV_INACTIVE  = 5;

  // Pin levels (active-low button)
  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

endpackage
`default_nettype wire

// File: hdl/button_press_event_classifier_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_event_classifier_top
// Classifies a stream of sampled button levels into press, release, short,
// long, long-release and inactivity events, one result beat per tick beat.
// ----------------------------------------------------------------------------
// The result of an accepted tick beat is in the output register in the next cycle.
// Throughput: 1 beat per cycle unless out_tready is low; the event and next-state
//   logic is combinational. A result held by out_tready low blocks the input, and
//   the next tick beat enters in the cycle the waiting result leaves.
// Reset: synchronous, active-low rst_n; state, configuration registers and output
//   valid return to reset values at once, with no clearing pass (not out_tdata).
module button_press_event_classifier_top #(
  parameter int HOLD_COUNT_BITS = bpec_pkg::HOLD_COUNT_BITS_DEF,
  parameter int IDLE_COUNT_BITS = bpec_pkg::IDLE_COUNT_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // tick input
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [bpec_pkg::IN_TDATA_BITS-1:0]    in_tdata,   // [0] pin_level
  // event output
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // [0] press, [1] release, [2] short_press, [3] long_press,
  // [4] long_release, [5] inactive
  output logic [bpec_pkg::OUT_TDATA_BITS-1:0]        out_tdata,
  // configuration write
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [bpec_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [bpec_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int LW = bpec_pkg::LONG_TICKS_BITS;
  localparam int DW = bpec_pkg::DEBOUNCE_TICKS_BITS;
  localparam int IW = bpec_pkg::INACTIVE_TICKS_BITS;
  // compare widths covering both counter and threshold
  localparam int HCW = (HOLD_COUNT_BITS > LW) ?
                       ((HOLD_COUNT_BITS > DW) ? HOLD_COUNT_BITS : DW) :
                       ((LW > DW) ? LW : DW);
  localparam int ICW = (IDLE_COUNT_BITS > IW) ? IDLE_COUNT_BITS : IW;

  // configuration registers
  logic [LW-1:0] long_ticks_r;
  logic [DW-1:0] debounce_ticks_r;
  logic          inactive_en_r;
  logic [IW-1:0] inactive_ticks_r;

  // classifier state
  logic                       prev_level_r,  prev_level_nxt;
  logic [HOLD_COUNT_BITS-1:0] hold_cnt_r,    hold_cnt_nxt;
  logic                       long_fired_r,  long_fired_nxt;
  logic [IDLE_COUNT_BITS-1:0] idle_cnt_r,    idle_cnt_nxt;
  logic                       idle_fired_r,  idle_fired_nxt;

  // output register
  logic                                out_valid_r;
  logic [bpec_pkg::OUT_TDATA_BITS-1:0] out_data_r, out_data_nxt;

  logic in_accept;
  logic level;
  logic [HOLD_COUNT_BITS-1:0] hold_inc;
  logic [IDLE_COUNT_BITS-1:0] idle_base;
  logic [IDLE_COUNT_BITS-1:0] idle_inc;
  logic                       idle_fired_base;
  logic [bpec_pkg::NUM_EVENTS-1:0] ev;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign level      = in_tdata[0];

  // saturating increments
  assign hold_inc = (&hold_cnt_r) ? hold_cnt_r : hold_cnt_r + 1'b1;
  assign idle_inc = (&idle_base)  ? idle_base  : idle_base + 1'b1;

  // release tick restarts the inactivity timer before it counts
  assign idle_base       = (prev_level_r == bpec_pkg::LVL_PRESSED) ? '0 : idle_cnt_r;
  assign idle_fired_base = (prev_level_r == bpec_pkg::LVL_PRESSED) ? 1'b0 : idle_fired_r;

  // per-tick event and state logic
  always_comb begin
    ev             = '0;
    prev_level_nxt = level;
    hold_cnt_nxt   = hold_cnt_r;
    long_fired_nxt = long_fired_r;
    idle_cnt_nxt   = idle_cnt_r;
    idle_fired_nxt = idle_fired_r;
    if (level == bpec_pkg::LVL_PRESSED) begin
      idle_cnt_nxt   = '0;
      idle_fired_nxt = 1'b0;
      if (prev_level_r == bpec_pkg::LVL_RELEASED) begin
        ev[bpec_pkg::EV_PRESS] = 1'b1;
        hold_cnt_nxt   = '0;
        long_fired_nxt = 1'b0;
      end else begin
        hold_cnt_nxt = hold_inc;
        if ((HCW'(hold_inc) >= HCW'(long_ticks_r)) && !long_fired_r) begin
          ev[bpec_pkg::EV_LONG] = 1'b1;
          long_fired_nxt = 1'b1;
        end
      end
    end else begin
      idle_cnt_nxt   = idle_base;
      idle_fired_nxt = idle_fired_base;
      if (prev_level_r == bpec_pkg::LVL_PRESSED) begin
        ev[bpec_pkg::EV_RELEASE] = 1'b1;
        if (long_fired_r) begin
          ev[bpec_pkg::EV_LONG_REL] = 1'b1;
        end else if (HCW'(hold_cnt_r) >= HCW'(debounce_ticks_r)) begin
          ev[bpec_pkg::EV_SHORT] = 1'b1;
        end
        hold_cnt_nxt   = '0;
        long_fired_nxt = 1'b0;
      end
      if (inactive_en_r && (inactive_ticks_r != '0) && !idle_fired_base) begin
        idle_cnt_nxt = idle_inc;
        if (ICW'(idle_inc) >= ICW'(inactive_ticks_r)) begin
          ev[bpec_pkg::EV_INACTIVE] = 1'b1;
          idle_fired_nxt = 1'b1;
        end
      end
    end
    out_data_nxt = bpec_pkg::OUT_TDATA_BITS'(ev);
  end

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r     <= bpec_pkg::LONG_TICKS_RST;
      debounce_ticks_r <= bpec_pkg::DEBOUNCE_TICKS_RST;
      inactive_en_r    <= 1'b0;
      inactive_ticks_r <= bpec_pkg::INACTIVE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpec_pkg::REG_LONG_PRESS_TICKS: long_ticks_r     <= cfg_data[LW-1:0];
        bpec_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_r <= cfg_data[DW-1:0];
        bpec_pkg::REG_INACTIVE_ENABLE:  inactive_en_r    <= cfg_data[0];
        bpec_pkg::REG_INACTIVE_TICKS:   inactive_ticks_r <= cfg_data[IW-1:0];
        default: ;
      endcase
    end
  end

  // state update on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= bpec_pkg::LVL_RELEASED;
      hold_cnt_r   <= '0;
      long_fired_r <= 1'b0;
      idle_cnt_r   <= '0;
      idle_fired_r <= 1'b0;
    end else if (in_accept) begin
      prev_level_r <= prev_level_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      long_fired_r <= long_fired_nxt;
      idle_cnt_r   <= idle_cnt_nxt;
      idle_fired_r <= idle_fired_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  a_short_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[bpec_pkg::EV_SHORT] || out_tdata[bpec_pkg::EV_LONG_REL])
      |-> out_tdata[bpec_pkg::EV_RELEASE])
    else $error("short or long release without release");

  a_short_long_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[bpec_pkg::EV_SHORT] && out_tdata[bpec_pkg::EV_LONG_REL]))
    else $error("short and long release together");

  a_press_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[bpec_pkg::EV_PRESS] && out_tdata[bpec_pkg::EV_RELEASE]))
    else $error("press and release together");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
    long_fired_r && (prev_level_r == bpec_pkg::LVL_PRESSED) && in_accept
      && (level == bpec_pkg::LVL_PRESSED) |=> !out_tdata[bpec_pkg::EV_LONG])
    else $error("long press raised twice in one hold");

endmodule
`default_nettype wire
